[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

[src/lfi_pkg.sv]
// ---------------------------------------------------------------------------
// lfi_pkg
// Types, codes and constants of the launcher fire interlock.
// ---------------------------------------------------------------------------
package lfi_pkg;

  // Bank geometry defaults
  localparam int LAUNCHER_COUNT_DEF       = 2;
  localparam int TIMINGS_PER_LAUNCHER_DEF = 5;

  // Number of timing words carried by a result
  localparam int TIMING_OUT_COUNT = 5;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 16;

  // Threshold reset values: 21.75 V and 20.25 V at 160.5022 counts/V, rounded up
  localparam logic [SAMPLE_W-1:0] CHARGED_THR_RESET    = 12'd3491;
  localparam logic [SAMPLE_W-1:0] DISCHARGED_THR_RESET = 12'd3251;

  // Driver delay compensation in microseconds
  localparam logic [TIME_W-1:0] ON_COMP  = 16'd2;
  localparam logic [TIME_W-1:0] OFF_COMP = 16'd4;

  // Configuration register indexes
  localparam logic CFG_CHARGED_THR    = 1'b0;
  localparam logic CFG_DISCHARGED_THR = 1'b1;

  typedef enum logic [2:0] {
    OP_SAMPLE         = 3'd0,
    OP_SET_TIMING     = 3'd1,
    OP_ARM            = 3'd2,
    OP_SAFETY_DISABLE = 3'd3,
    OP_FIRE           = 3'd4,
    OP_SEQ_DONE       = 3'd5,
    OP_RELOAD         = 3'd6,
    OP_STATUS         = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_KILLED        = 4'd1,
    ERR_KILL_ASSERTED = 4'd2,
    ERR_NOT_ARMED     = 4'd3,
    ERR_ALL_FIRED     = 4'd4,
    ERR_ALREADY_FIRING = 4'd5,
    ERR_NOT_CHARGED   = 4'd6,
    ERR_MISSING_TIMING = 4'd7,
    ERR_FIRING_BUSY   = 4'd8,
    ERR_REJECTED      = 4'd9
  } err_t;

  typedef enum logic [2:0] {
    ST_UNINIT   = 3'd0,
    ST_DISARMED = 3'd1,
    ST_FIRING   = 3'd2,
    ST_READY    = 3'd3,
    ST_CHARGING = 3'd4
  } status_t;

endpackage

[src/launcher_fire_interlock_core.sv]
// ---------------------------------------------------------------------------
// launcher_fire_interlock_core
// Interlock and sequencing controller for a bank of coil launchers.
// ---------------------------------------------------------------------------
// Throughput: one event per cycle while the result register is not held by out_stall; it frees as it is taken.
// Each event is decoded and checked in one pass of compares over the
// register-held timing store and flags, then captured in the result register.
// Reset clears all flags, the timing store valid bits and the result valid
// flag, and restores both charge thresholds.
module launcher_fire_interlock_core
  import lfi_pkg::*;
#(
  parameter int LAUNCHER_COUNT       = LAUNCHER_COUNT_DEF,
  parameter int TIMINGS_PER_LAUNCHER = TIMINGS_PER_LAUNCHER_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // event channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          operation,
  input  logic                system_armed,
  input  logic                kill_asserted,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  logic [1:0]          launcher_number,
  input  logic [2:0]          timing_kind,
  input  logic [TIME_W-1:0]   time_us,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                accepted,
  output logic [3:0]          error_code,
  output logic [2:0]          state_code,
  output logic [1:0]          select_line,
  output logic                arm_output,
  output logic                fault_raised,
  output logic [TIME_W-1:0]   timing_first,
  output logic [TIME_W-1:0]   timing_second,
  output logic [TIME_W-1:0]   timing_third,
  output logic [TIME_W-1:0]   timing_fourth,
  output logic [TIME_W-1:0]   timing_fifth,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int ROW_W  = (LAUNCHER_COUNT > 1) ? $clog2(LAUNCHER_COUNT) : 1;
  localparam int SLOT_W = (TIMINGS_PER_LAUNCHER > 1) ? $clog2(TIMINGS_PER_LAUNCHER) : 1;
  localparam logic [1:0] NL_COUNT  = 2'(LAUNCHER_COUNT);
  localparam logic [2:0] TPL_COUNT = 3'(TIMINGS_PER_LAUNCHER);

  // State
  logic [TIME_W-1:0]   timing_store [LAUNCHER_COUNT][TIMINGS_PER_LAUNCHER];
  logic                timing_set   [LAUNCHER_COUNT][TIMINGS_PER_LAUNCHER];
  logic [1:0]          next_launcher;
  logic                firing_active;
  logic                charged_flag;
  logic [SAMPLE_W-1:0] latest_sample;
  logic                armed_level;
  logic [1:0]          selected_line;
  logic [SAMPLE_W-1:0] charged_threshold;
  logic [SAMPLE_W-1:0] discharged_threshold;

  // Next state
  logic [1:0]          next_launcher_next;
  logic                firing_active_next;
  logic                charged_flag_next;
  logic [SAMPLE_W-1:0] latest_sample_next;
  logic                armed_level_next;
  logic [1:0]          selected_line_next;

  // Store write port
  logic                store_we;
  logic [ROW_W-1:0]    store_row;
  logic [SLOT_W-1:0]   store_slot;
  logic [TIME_W-1:0]   store_data;

  // Result of the current event
  logic                res_accepted;
  err_t                res_err;
  status_t             res_state;
  logic                res_fault;
  logic                res_fire;

  // Derived checks
  logic                in_accept;
  op_t                 op;
  logic                all_set;
  logic                row_set;
  logic                charge_eval;
  logic [TIME_W-1:0]   comp;
  logic [ROW_W-1:0]    row_sel;
  logic [TIME_W-1:0]   fire_tim [TIMING_OUT_COUNT];

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;
  assign op        = op_t'(operation);

  // Pick the row of the next launcher to fire
  assign row_sel = (next_launcher < NL_COUNT) ? ROW_W'(next_launcher) : '0;

  // Gather timings of that row, zero past the row width
  for (genvar g = 0; g < TIMING_OUT_COUNT; g++) begin : g_fire_tim
    if (g < TIMINGS_PER_LAUNCHER) begin : g_used
      assign fire_tim[g] = timing_store[row_sel][g];
    end else begin : g_unused
      assign fire_tim[g] = '0;
    end
  end

  // Check for unset slots in the whole store and in the selected row
  always_comb begin
    all_set = 1'b1;
    row_set = 1'b1;
    for (int r = 0; r < LAUNCHER_COUNT; r++) begin
      for (int k = 0; k < TIMINGS_PER_LAUNCHER; k++) begin
        all_set = all_set & timing_set[r][k];
      end
    end
    for (int k = 0; k < TIMINGS_PER_LAUNCHER; k++) begin
      row_set = row_set & timing_set[row_sel][k];
    end
  end

  // Evaluate charge with hysteresis
  assign charge_eval = charged_flag ? (latest_sample >= discharged_threshold)
                                    : (latest_sample >= charged_threshold);

  // Compensation: even slots are coil-on, odd slots coil-off
  assign comp = timing_kind[0] ? OFF_COMP : ON_COMP;

  // Decode the event word and compute its result and the next state
  always_comb begin
    res_accepted       = 1'b1;
    res_err            = ERR_NONE;
    res_state          = ST_UNINIT;
    res_fault          = 1'b0;
    res_fire           = 1'b0;
    next_launcher_next = next_launcher;
    firing_active_next = firing_active;
    charged_flag_next  = charged_flag;
    latest_sample_next = latest_sample;
    armed_level_next   = armed_level;
    selected_line_next = selected_line;
    store_we           = 1'b0;
    store_row          = ROW_W'(launcher_number - 2'd1);
    store_slot         = SLOT_W'(timing_kind);
    store_data         = time_us - comp;

    case (op)
      OP_SAMPLE: begin
        latest_sample_next = sample_value;
      end
      OP_SET_TIMING: begin
        if (launcher_number == 2'd0 || launcher_number > NL_COUNT ||
            timing_kind >= TPL_COUNT || time_us < comp || system_armed) begin
          res_accepted = 1'b0;
          res_err      = ERR_REJECTED;
        end else begin
          store_we = 1'b1;
        end
      end
      OP_ARM: begin
        if (!system_armed) begin
          res_accepted = 1'b0;
          res_err      = ERR_KILLED;
        end else begin
          next_launcher_next = 2'd0;
          armed_level_next   = 1'b1;
        end
      end
      OP_SAFETY_DISABLE: begin
        selected_line_next = 2'd0;
        armed_level_next   = 1'b0;
        if (firing_active) begin
          firing_active_next = 1'b0;
          res_fault          = 1'b1;
        end
      end
      OP_FIRE: begin
        res_accepted = 1'b0;
        if (kill_asserted) begin
          res_err = ERR_KILL_ASSERTED;
        end else if (!system_armed) begin
          res_err = ERR_NOT_ARMED;
        end else if (next_launcher >= NL_COUNT) begin
          res_err = ERR_ALL_FIRED;
        end else if (firing_active) begin
          res_err = ERR_ALREADY_FIRING;
        end else begin
          charged_flag_next = charge_eval;
          if (!charge_eval) begin
            res_err = ERR_NOT_CHARGED;
          end else if (!row_set) begin
            res_err = ERR_MISSING_TIMING;
          end else begin
            res_accepted       = 1'b1;
            res_fire           = 1'b1;
            firing_active_next = 1'b1;
            selected_line_next = next_launcher + 2'd1;
          end
        end
      end
      OP_SEQ_DONE: begin
        selected_line_next = 2'd0;
        if (firing_active) begin
          firing_active_next = 1'b0;
          next_launcher_next = next_launcher + 2'd1;
        end
      end
      OP_RELOAD: begin
        if (firing_active) begin
          res_accepted = 1'b0;
          res_err      = ERR_FIRING_BUSY;
        end else begin
          next_launcher_next = 2'd0;
        end
      end
      OP_STATUS: begin
        if (!all_set) begin
          res_state = ST_UNINIT;
        end else if (!system_armed) begin
          res_state = ST_DISARMED;
        end else if (firing_active) begin
          res_state = ST_FIRING;
        end else begin
          charged_flag_next = charge_eval;
          res_state         = charge_eval ? ST_READY : ST_CHARGING;
        end
      end
      default: begin
        res_accepted = 1'b0;
      end
    endcase
  end

  // Hold control state, timing valid bits and thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      next_launcher        <= 2'd0;
      firing_active        <= 1'b0;
      charged_flag         <= 1'b0;
      latest_sample        <= '0;
      armed_level          <= 1'b0;
      selected_line        <= 2'd0;
      charged_threshold    <= CHARGED_THR_RESET;
      discharged_threshold <= DISCHARGED_THR_RESET;
      for (int r = 0; r < LAUNCHER_COUNT; r++) begin
        for (int k = 0; k < TIMINGS_PER_LAUNCHER; k++) begin
          timing_set[r][k] <= 1'b0;
        end
      end
    end else begin
      if (in_accept) begin
        next_launcher <= next_launcher_next;
        firing_active <= firing_active_next;
        charged_flag  <= charged_flag_next;
        latest_sample <= latest_sample_next;
        armed_level   <= armed_level_next;
        selected_line <= selected_line_next;
        if (store_we) begin
          timing_set[store_row][store_slot] <= (store_data != '0);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHARGED_THR:    charged_threshold    <= cfg_data;
          CFG_DISCHARGED_THR: discharged_threshold <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Write timing words; unset slots are masked by the valid bits
  always_ff @(posedge clk) begin
    if (in_accept && store_we) begin
      timing_store[store_row][store_slot] <= store_data;
    end
  end

  // Advance the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_accept || (out_valid && out_stall);
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      accepted      <= res_accepted;
      error_code    <= res_err;
      state_code    <= res_state;
      select_line   <= selected_line_next;
      arm_output    <= armed_level_next;
      fault_raised  <= res_fault;
      timing_first  <= res_fire ? fire_tim[0] : '0;
      timing_second <= res_fire ? fire_tim[1] : '0;
      timing_third  <= res_fire ? fire_tim[2] : '0;
      timing_fourth <= res_fire ? fire_tim[3] : '0;
      timing_fifth  <= res_fire ? fire_tim[4] : '0;
    end
  end

  // Assertions
  `ASSERT_IMPLIES(a_select_needs_firing, clk, rst, selected_line != 2'd0, firing_active, "select line driven without an active firing")
  `ASSERT_IMPLIES(a_accept_matches_err, clk, rst, out_valid, accepted == (error_code == ERR_NONE), "accepted flag disagrees with error code")
  `ASSERT_IMPLIES(a_next_in_range, clk, rst, 1'b1, next_launcher <= NL_COUNT, "next launcher beyond bank")
  `ASSERT_NEXT(a_fire_starts, clk, rst, in_accept && res_fire, firing_active && out_valid, "successful fire did not start a firing")

endmodule
